[src/gcts_pkg.sv]
// ----------------------------------------------------------------------------
// gcts_pkg
// Shared widths, register indexes and the per-tile context word for the
// grouped channel tile split pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package gcts_pkg;

  localparam int TILE_W     = 12;
  localparam int CH_W       = 20;
  localparam int GRP_W      = 16;
  localparam int TCNT_W     = 13;
  localparam int SHARE_W    = CH_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam int DIV_NW  = 34;
  localparam int DIV_DW  = 16;
  localparam int DIV_LAT = DIV_NW;

  localparam int LATENCY = 4 * DIV_LAT + 11;

  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_CHANNELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_WIDTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_TOTAL     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TILES_PER_CHIP = 2'd3;

  typedef struct packed {
    logic               in_range;
    logic               prop;
    logic               grp_ok;
    logic [CH_W-1:0]    prop_start;
    logic [CH_W-1:0]    prop_count;
    logic [TCNT_W-1:0]  chip;
    logic [TCNT_W-1:0]  slot;
    logic [SHARE_W-1:0] share;
    logic [DIV_NW-1:0]  base;
    logic [CH_W-1:0]    chip_ch;
  } ctx_t;

endpackage

`default_nettype wire

[src/grouped_channel_tile_split.sv]
// ----------------------------------------------------------------------------
// grouped_channel_tile_split
// Returns the first channel, channel count and group size for one tile.
// ----------------------------------------------------------------------------
// A query word is taken on a clock edge with start high and busy low; busy
// is always low, so a new tile index may be given in every cycle. The result
// word appears on first_channel_o, channel_count_o and group_in_use_o with
// valid_o high for exactly one cycle. Results leave in query order, one per
// query, and the receiver cannot stall them. The path runs through four
// chained 34-stage pipelined dividers (tile bounds, chip share, chip groups,
// tile share) plus eleven stages of multiply, add and compare between
// them. Throughput is one query per cycle.
// Registers are written through cfg_we_i, cfg_idx_i and cfg_wdata_i and
// must only change while no query is in flight. Reset clears all valid bits
// and loads the register defaults: zero channels, group width one, one tile
// and one tile per chip.
// ----------------------------------------------------------------------------
`default_nettype none

module grouped_channel_tile_split import gcts_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [TILE_W-1:0]     tile_index_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output logic                  valid_o,
  output logic [CH_W-1:0]       first_channel_o,
  output logic [CH_W-1:0]       channel_count_o,
  output logic [GRP_W-1:0]      group_in_use_o
);

  function automatic logic [CH_W-1:0] take(input logic [DIV_NW-1:0] avail,
                                           input logic [DIV_NW-1:0] used,
                                           input logic [DIV_NW-1:0] cap);
    logic [DIV_NW-1:0] left;
    left = avail - used;
    if (used >= avail) begin
      return '0;
    end else if (left < cap) begin
      return left[CH_W-1:0];
    end else begin
      return cap[CH_W-1:0];
    end
  endfunction

  logic [CH_W-1:0]   tot_q;
  logic [GRP_W-1:0]  grp_q;
  logic [TCNT_W-1:0] tt_q;
  logic [TCNT_W-1:0] tpc_q;
  logic [GRP_W-1:0]  g_eff;
  logic [TCNT_W-1:0] p_eff;

  assign g_eff = (grp_q == '0) ? GRP_W'(1) : grp_q;
  assign p_eff = (tpc_q == '0) ? TCNT_W'(1) : tpc_q;
  assign busy  = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_q <= '0;
      grp_q <= GRP_W'(1);
      tt_q  <= TCNT_W'(1);
      tpc_q <= TCNT_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TOTAL_CHANNELS: tot_q <= cfg_wdata_i[CH_W-1:0];
        REG_GROUP_WIDTH:    grp_q <= cfg_wdata_i[GRP_W-1:0];
        REG_TILE_TOTAL:     tt_q  <= cfg_wdata_i[TCNT_W-1:0];
        REG_TILES_PER_CHIP: tpc_q <= cfg_wdata_i[TCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: capture, products, rounding offsets.
  logic              v1_q, v2_q, v3_q;
  logic [TILE_W-1:0] t1_q, t2_q, t3_q;
  logic [31:0]       plo2_q;
  logic [32:0]       phi2_q;
  logic [DIV_NW-1:0] nlo3_q, nhi3_q;
  logic              inr3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start && !busy;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      t1_q <= tile_index_i;
    end
    t2_q   <= t1_q;
    plo2_q <= 32'(t1_q) * 32'(tot_q);
    phi2_q <= 33'(({1'b0, t1_q} + 13'd1)) * 33'(tot_q);
    t3_q   <= t2_q;
    nlo3_q <= 34'(plo2_q) + 34'(tt_q) - 34'd1;
    nhi3_q <= 34'(phi2_q) + 34'(tt_q) - 34'd1;
    inr3_q <= {1'b0, t2_q} < tt_q;
  end

  logic [DIV_NW-1:0] q_lo, q_hi, q_cg, q_ch, q_tp;
  logic [DIV_DW-1:0] r_lo, r_hi, r_cg, r_ch, r_tp;

  gcts_div u_div_lo (.clk_i, .num_i(nlo3_q), .den_i(DIV_DW'(tt_q)),
                     .quo_o(q_lo), .rem_o(r_lo));
  gcts_div u_div_hi (.clk_i, .num_i(nhi3_q), .den_i(DIV_DW'(tt_q)),
                     .quo_o(q_hi), .rem_o(r_hi));
  gcts_div u_div_cg (.clk_i, .num_i(DIV_NW'(tot_q)), .den_i(g_eff),
                     .quo_o(q_cg), .rem_o(r_cg));
  gcts_div u_div_ch (.clk_i, .num_i(DIV_NW'(tt_q)), .den_i(DIV_DW'(p_eff)),
                     .quo_o(q_ch), .rem_o(r_ch));
  gcts_div u_div_tp (.clk_i, .num_i(DIV_NW'(t3_q)), .den_i(DIV_DW'(p_eff)),
                     .quo_o(q_tp), .rem_o(r_tp));

  logic vA_q [DIV_LAT];
  logic irA_q [DIV_LAT];
  logic vB_q [DIV_LAT];
  logic vC_q [DIV_LAT];
  logic vD_q [DIV_LAT];
  ctx_t cB_q [DIV_LAT];
  ctx_t cC_q [DIV_LAT];
  ctx_t cD_q [DIV_LAT];

  logic              v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, v10_q;
  ctx_t              c4_q, c5_q, c6_q, c7_q, c8_q, c9_q, c10_q;
  ctx_t              c4_d, c5_d, c6_d, c7_d, c9_d, c10_d;
  logic [TCNT_W-1:0] chips;
  logic [DIV_NW-1:0] ncs4_q, nts8_q;
  logic [TCNT_W-1:0] dcs4_q;
  logic [DIV_NW-1:0] q_cs, q_ct, q_ts;
  logic [DIV_DW-1:0] r_cs, r_ct, r_ts;

  assign chips = q_ch[TCNT_W-1:0];

  always_comb begin
    c4_d            = '0;
    c4_d.in_range   = irA_q[DIV_LAT-1];
    c4_d.prop       = r_cg != '0;
    c4_d.prop_start = q_lo[CH_W-1:0];
    c4_d.prop_count = CH_W'(q_hi - q_lo);
    c4_d.chip       = q_tp[TCNT_W-1:0];
    c4_d.slot       = r_tp[TCNT_W-1:0];
    c4_d.grp_ok     = (chips != '0) && (q_tp[TCNT_W-1:0] < chips);
  end

  always_comb begin
    c5_d          = cB_q[DIV_LAT-1];
    c5_d.share    = SHARE_W'(37'(q_cs[SHARE_W-1:0]) * 37'(g_eff));
    c6_d          = c5_q;
    c6_d.base     = DIV_NW'(c5_q.chip) * DIV_NW'(c5_q.share);
    c7_d          = c6_q;
    c7_d.chip_ch  = take(DIV_NW'(tot_q), c6_q.base, DIV_NW'(c6_q.share));
    c9_d          = cD_q[DIV_LAT-1];
    c9_d.share    = SHARE_W'(37'(q_ts[SHARE_W-1:0]) * 37'(g_eff));
    c10_d         = c9_q;
    c10_d.base    = DIV_NW'(c9_q.slot) * DIV_NW'(c9_q.share);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        vA_q[k] <= 1'b0;
        vB_q[k] <= 1'b0;
        vC_q[k] <= 1'b0;
        vD_q[k] <= 1'b0;
      end
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
    end else begin
      vA_q[0] <= v3_q;
      vB_q[0] <= v4_q;
      vC_q[0] <= v7_q;
      vD_q[0] <= v8_q;
      for (int k = 1; k < DIV_LAT; k++) begin
        vA_q[k] <= vA_q[k-1];
        vB_q[k] <= vB_q[k-1];
        vC_q[k] <= vC_q[k-1];
        vD_q[k] <= vD_q[k-1];
      end
      v4_q  <= vA_q[DIV_LAT-1];
      v5_q  <= vB_q[DIV_LAT-1];
      v6_q  <= v5_q;
      v7_q  <= v6_q;
      v8_q  <= vC_q[DIV_LAT-1];
      v9_q  <= vD_q[DIV_LAT-1];
      v10_q <= v9_q;
    end
  end

  always_ff @(posedge clk_i) begin
    irA_q[0] <= inr3_q;
    cB_q[0]  <= c4_q;
    cC_q[0]  <= c7_q;
    cD_q[0]  <= c8_q;
    for (int k = 1; k < DIV_LAT; k++) begin
      irA_q[k] <= irA_q[k-1];
      cB_q[k]  <= cB_q[k-1];
      cC_q[k]  <= cC_q[k-1];
      cD_q[k]  <= cD_q[k-1];
    end
    c4_q   <= c4_d;
    ncs4_q <= q_cg + DIV_NW'(chips) - DIV_NW'(1);
    dcs4_q <= (chips == '0) ? TCNT_W'(1) : chips;

    c5_q <= c5_d;
    c6_q <= c6_d;
    c7_q <= c7_d;

    c8_q   <= cC_q[DIV_LAT-1];
    nts8_q <= q_ct + DIV_NW'(p_eff) - DIV_NW'(1);

    c9_q  <= c9_d;
    c10_q <= c10_d;
  end

  // c9 and c10 reuse share for the tile share; c10.base holds the tile
  // offset while the chip base is carried from c9.
  logic [DIV_NW-1:0] chip_base10_q;
  always_ff @(posedge clk_i) begin
    chip_base10_q <= c9_q.base;
  end

  gcts_div u_div_cs (.clk_i, .num_i(ncs4_q), .den_i(DIV_DW'(dcs4_q)),
                     .quo_o(q_cs), .rem_o(r_cs));
  gcts_div u_div_ct (.clk_i, .num_i(DIV_NW'(c7_q.chip_ch)), .den_i(g_eff),
                     .quo_o(q_ct), .rem_o(r_ct));
  gcts_div u_div_ts (.clk_i, .num_i(nts8_q), .den_i(DIV_DW'(p_eff)),
                     .quo_o(q_ts), .rem_o(r_ts));

  logic [CH_W-1:0]   cnt_d, st_d;
  logic [CH_W-1:0]   grp_cnt;
  logic [DIV_NW-1:0] grp_st;

  always_comb begin
    grp_cnt = take(DIV_NW'(c10_q.chip_ch), c10_q.base, DIV_NW'(c10_q.share));
    grp_st  = chip_base10_q + c10_q.base;
    if (c10_q.prop) begin
      cnt_d = c10_q.in_range ? c10_q.prop_count : '0;
      st_d  = c10_q.prop_start;
    end else begin
      cnt_d = (c10_q.in_range && c10_q.grp_ok) ? grp_cnt : '0;
      st_d  = grp_st[CH_W-1:0];
    end
    if (cnt_d == '0) begin
      st_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= v10_q;
    end
  end

  always_ff @(posedge clk_i) begin
    first_channel_o <= st_d;
    channel_count_o <= cnt_d;
    group_in_use_o  <= c10_q.prop ? GRP_W'(1) : g_eff;
  end

  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##LATENCY valid_o)
    else $error("query result missing after pipeline latency");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && channel_count_o == '0 |-> first_channel_o == '0)
    else $error("empty tile reports a nonzero first channel");

  a_grp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> group_in_use_o != '0)
    else $error("group size in use is zero");

  a_nostray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valid_o) |-> $past(v10_q))
    else $error("result word without a query behind it");

endmodule

`default_nettype wire

[src/gcts_div.sv]
// ----------------------------------------------------------------------------
// gcts_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module gcts_div import gcts_pkg::*; (
  input  logic              clk_i,
  input  logic [DIV_NW-1:0] num_i,
  input  logic [DIV_DW-1:0] den_i,
  output logic [DIV_NW-1:0] quo_o,
  output logic [DIV_DW-1:0] rem_o
);

  logic [DIV_NW-1:0] num_q [DIV_NW];
  logic [DIV_NW-1:0] quo_q [DIV_NW];
  logic [DIV_DW-1:0] rem_q [DIV_NW];
  logic [DIV_DW-1:0] den_q [DIV_NW];

  logic [DIV_NW-1:0] num_s [DIV_NW];
  logic [DIV_NW-1:0] quo_s [DIV_NW];
  logic [DIV_DW-1:0] rem_s [DIV_NW];
  logic [DIV_DW-1:0] den_s [DIV_NW];
  logic [DIV_DW:0]   trial [DIV_NW];
  logic [DIV_NW-1:0] quo_d [DIV_NW];
  logic [DIV_DW-1:0] rem_d [DIV_NW];

  always_comb begin
    for (int s = 0; s < DIV_NW; s++) begin
      if (s == 0) begin
        num_s[s] = num_i;
        den_s[s] = den_i;
        rem_s[s] = '0;
        quo_s[s] = '0;
      end else begin
        num_s[s] = num_q[s-1];
        den_s[s] = den_q[s-1];
        rem_s[s] = rem_q[s-1];
        quo_s[s] = quo_q[s-1];
      end
      trial[s] = {rem_s[s], num_s[s][DIV_NW-1-s]};
      if (trial[s] >= {1'b0, den_s[s]}) begin
        rem_d[s] = DIV_DW'(trial[s] - {1'b0, den_s[s]});
        quo_d[s] = quo_s[s] | (DIV_NW'(1) << (DIV_NW-1-s));
      end else begin
        rem_d[s] = trial[s][DIV_DW-1:0];
        quo_d[s] = quo_s[s];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < DIV_NW; s++) begin
      num_q[s] <= num_s[s];
      den_q[s] <= den_s[s];
      rem_q[s] <= rem_d[s];
      quo_q[s] <= quo_d[s];
    end
  end

  assign quo_o = quo_q[DIV_NW-1];
  assign rem_o = rem_q[DIV_NW-1];

endmodule

`default_nettype wire

[dv/grouped_channel_tile_split_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grouped_channel_tile_split_checker
// Watches the query, register and result ports of the tile split block,
// keeps its own copy of the registers, predicts the channel range of every
// accepted tile index and compares each result word against the oldest
// prediction in order.
// ----------------------------------------------------------------------------
module grouped_channel_tile_split_checker import gcts_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  busy_i,
  input  logic [TILE_W-1:0]     tile_index_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  valid_i,
  input  logic [CH_W-1:0]       first_channel_i,
  input  logic [CH_W-1:0]       channel_count_i,
  input  logic [GRP_W-1:0]      group_in_use_i,
  output int                    errors_o,
  output int                    pending_o
);

  typedef struct packed {
    logic [CH_W-1:0]  first;
    logic [CH_W-1:0]  count;
    logic [GRP_W-1:0] grp;
  } range_t;

  range_t            ranges_due[$];
  logic [CH_W-1:0]   chan_total;
  logic [GRP_W-1:0]  grp_width;
  logic [TCNT_W-1:0] tiles_all;
  logic [TCNT_W-1:0] tiles_chip;

  function automatic longint unsigned ceil_div(longint unsigned a, longint unsigned b);
    return (a + b - 1) / b;
  endfunction

  function automatic longint unsigned clip_rest(longint unsigned avail,
                                                longint unsigned used,
                                                longint unsigned cap);
    if (used >= avail) return 0;
    return (avail - used < cap) ? avail - used : cap;
  endfunction

  function automatic range_t tile_range(logic [TILE_W-1:0] tile);
    longint unsigned t, c, g, n, p, first, count;
    longint unsigned chips, chip, slot, chip_share, chip_base, chip_ch, tile_share, off;
    range_t r;
    t = tile;
    c = chan_total;
    g = (grp_width == 0) ? 1 : grp_width;
    n = tiles_all;
    p = (tiles_chip == 0) ? 1 : tiles_chip;
    first = 0;
    count = 0;
    if (c % g != 0) begin
      g = 1;
      if (t < n && t < 4096) begin
        first = ceil_div(t * c, n);
        count = ceil_div((t + 1) * c, n) - first;
      end
    end else if (t < n && t < 4096) begin
      chips = n / p;
      chip  = t / p;
      slot  = t % p;
      if (chips != 0 && chip < chips) begin
        chip_share = ceil_div(c / g, chips) * g;
        chip_base  = chip * chip_share;
        chip_ch    = clip_rest(c, chip_base, chip_share);
        tile_share = ceil_div(chip_ch / g, p) * g;
        off        = slot * tile_share;
        count      = clip_rest(chip_ch, off, tile_share);
        first      = chip_base + off;
      end
    end
    if (count == 0) first = 0;
    r.first = first[CH_W-1:0];
    r.count = count[CH_W-1:0];
    r.grp   = g[GRP_W-1:0];
    return r;
  endfunction

  assign pending_o = ranges_due.size();

  always @(posedge clk_i or negedge rst_ni) begin
    range_t want;
    if (!rst_ni) begin
      chan_total <= '0;
      grp_width  <= GRP_W'(1);
      tiles_all  <= TCNT_W'(1);
      tiles_chip <= TCNT_W'(1);
      errors_o   <= 0;
      ranges_due.delete();
    end else begin
      if (start_i && !busy_i) ranges_due.push_back(tile_range(tile_index_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TOTAL_CHANNELS: chan_total <= cfg_wdata_i[CH_W-1:0];
          REG_GROUP_WIDTH:    grp_width  <= cfg_wdata_i[GRP_W-1:0];
          REG_TILE_TOTAL:     tiles_all  <= cfg_wdata_i[TCNT_W-1:0];
          REG_TILES_PER_CHIP: tiles_chip <= cfg_wdata_i[TCNT_W-1:0];
          default: ;
        endcase
      end
      if (valid_i) begin
        if (ranges_due.size() == 0) begin
          if (errors_o < 10) $display("unexpected result word: first %0d count %0d group %0d",
                                      first_channel_i, channel_count_i, group_in_use_i);
          errors_o <= errors_o + 1;
        end else begin
          want = ranges_due.pop_front();
          if (want.first !== first_channel_i || want.count !== channel_count_i ||
              want.grp !== group_in_use_i) begin
            if (errors_o < 10)
              $display("mismatch: first %0d/%0d count %0d/%0d group %0d/%0d (exp/act)",
                       want.first, first_channel_i, want.count, channel_count_i,
                       want.grp, group_in_use_i);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

[dv/grouped_channel_tile_split_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grouped_channel_tile_split_test
// Drives tile index queries through the tile split block under a series of
// register settings, fixed extremes first and random ones after, with random
// gaps between queries; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module grouped_channel_tile_split_test;
  import gcts_pkg::*;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [TILE_W-1:0]     tile_index = '0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  valid;
  logic [CH_W-1:0]       first_channel;
  logic [CH_W-1:0]       channel_count;
  logic [GRP_W-1:0]      group_in_use;
  int                    errors;
  int                    pending;
  int                    quiet_cycles = 0;
  bit                    gaps_on = 1'b1;
  int unsigned           fixed_set [9][4] = '{
    '{0, 1, 1, 1}, '{1048575, 1, 4096, 1}, '{1048575, 2, 4096, 4096},
    '{1048560, 65535, 4096, 4096}, '{1048560, 65535, 4096, 1},
    '{1000, 10, 7, 3}, '{999, 0, 13, 4}, '{64, 8, 5, 6}, '{100, 4, 10, 0}};

  always #6 clk_i = ~clk_i;

  grouped_channel_tile_split dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .tile_index_i(tile_index), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_wdata_i(cfg_wdata), .valid_o(valid), .first_channel_o(first_channel),
    .channel_count_o(channel_count), .group_in_use_o(group_in_use)
  );

  grouped_channel_tile_split_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start), .busy_i(busy),
    .tile_index_i(tile_index), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_wdata_i(cfg_wdata), .valid_i(valid), .first_channel_i(first_channel),
    .channel_count_i(channel_count), .group_in_use_i(group_in_use),
    .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    if ((start && !busy) || valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 3000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value[CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic load_split(int unsigned c, int unsigned g, int unsigned n, int unsigned p);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    write_reg(REG_TOTAL_CHANNELS, c);
    write_reg(REG_GROUP_WIDTH, g);
    write_reg(REG_TILE_TOTAL, n);
    write_reg(REG_TILES_PER_CHIP, p);
  endtask

  task automatic ask_tile(int unsigned t);
    start      <= 1'b1;
    tile_index <= t[TILE_W-1:0];
    forever begin
      @(negedge clk_i);
      if (!busy) break;
    end
    @(posedge clk_i);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  task automatic run_tiles(int unsigned n, int unsigned p, int count);
    ask_tile(0);
    ask_tile(4095);
    ask_tile(n - 1);
    ask_tile(n);
    ask_tile(p - 1);
    ask_tile(p);
    repeat (count) begin
      if ($urandom_range(0, 3) == 0) ask_tile($urandom_range(0, 4095));
      else ask_tile($urandom_range(0, n));
    end
    start <= 1'b0;
  endtask

  initial begin
    int unsigned c, g, n, p;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_tiles(1, 1, 4);
    foreach (fixed_set[i]) begin
      load_split(fixed_set[i][0], fixed_set[i][1], fixed_set[i][2], fixed_set[i][3]);
      run_tiles(fixed_set[i][2], fixed_set[i][3], 90);
    end
    for (int k = 0; k < 10; k++) begin
      gaps_on = (k < 7);
      g = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 64) : $urandom_range(1, 65535);
      if ($urandom_range(0, 3) != 0) c = g * $urandom_range(0, 1048575 / g);
      else c = $urandom_range(0, 1048575);
      n = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 64) : $urandom_range(1, 4096);
      p = ($urandom_range(0, 4) != 0) ? $urandom_range(1, n) : $urandom_range(1, 4096);
      load_split(c, g, n, p);
      run_tiles(n, p, 100);
    end
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

[sim.f]
src/gcts_pkg.sv
src/gcts_div.sv
src/grouped_channel_tile_split.sv
dv/grouped_channel_tile_split_checker.sv
dv/grouped_channel_tile_split_test.sv
